>>> hw/rtl/deque_ring_buffer_assert.svh
// Assertion macros for the double-ended queue checker.
// Each macro expands to one labelled concurrent assertion clocked on clk.
`ifndef DEQUE_RING_BUFFER_ASSERT_SVH
`define DEQUE_RING_BUFFER_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define DRB_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque_ring_buffer: same-cycle check failed");

// Consequent holds in the cycle after the antecedent.
`define DRB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque_ring_buffer: next-cycle check failed");

`endif

>>> hw/rtl/drb_pkg.sv
// Shared types and codes for the double-ended queue.
// No dependencies; used by every module of the block.
package drb_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int DATA_W       = 32;

    localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [2:0] ACT_POP_BACK   = 3'd3;
    localparam logic [2:0] ACT_DUMP_FWD   = 3'd4;
    localparam logic [2:0] ACT_DUMP_BWD   = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]               action;
        logic signed [DATA_W-1:0] value;
    } request_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] value_res;
        logic                     last;
    } result_t;

endpackage

>>> hw/rtl/drb_addr_unit.sv
// Shared slot adder: (base + offset) modulo CAPACITY.
// Depends on drb_pkg for the default capacity; both operands must be below CAPACITY, which the adder does not enforce.
module drb_addr_unit #(
    parameter int CAPACITY = drb_pkg::CAPACITY_DEF,
    localparam int IDX_W   = $clog2(CAPACITY)
) (
    input  logic [IDX_W-1:0] base,
    input  logic [IDX_W-1:0] offset,
    output logic [IDX_W-1:0] slot
);

    localparam logic [IDX_W:0] CAP_S = (IDX_W+1)'(CAPACITY);

    logic [IDX_W:0] sum;

    assign sum  = {1'b0, base} + {1'b0, offset};
    assign slot = (sum >= CAP_S) ? IDX_W'(sum - CAP_S) : sum[IDX_W-1:0];

endmodule

>>> hw/rtl/drb_mem.sv
// Entry store of the ring: one port, write and registered read per cycle.
// Depends on drb_pkg for the data width.
module drb_mem #(
    parameter int CAPACITY = drb_pkg::CAPACITY_DEF,
    localparam int IDX_W   = $clog2(CAPACITY)
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [IDX_W-1:0]                 addr,
    input  logic signed [drb_pkg::DATA_W-1:0] wdata,
    output logic signed [drb_pkg::DATA_W-1:0] rdata
);

    logic signed [drb_pkg::DATA_W-1:0] mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> hw/rtl/deque_ring_buffer.sv
// Top level of the double-ended queue: sequencer, front and occupancy registers.
// Depends on drb_pkg, drb_addr_unit and drb_mem.
//
//  channel   handshake         payload            accepted when
//  request   start / busy      request_t request  start && !busy at clk edge
//  result    strobe            result_t  result   strobe high, one cycle only
//
// Push: slot add and memory write in the execute state, then a registered result.
// Pop: slot add and read, then result. Full or empty answers come from the execute state.
// Dump: one memory read per entry through the single port.
// Unknown actions give no result. The one slot adder is shared by every step.
// Reset clears front and occupancy; the entry store has no reset.
module deque_ring_buffer #(
    parameter int CAPACITY = drb_pkg::CAPACITY_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  drb_pkg::request_t request,
    output logic              strobe,
    output drb_pkg::result_t  result
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int OCC_W = $clog2(CAPACITY + 1);
    localparam logic [OCC_W-1:0] CAP_OCC = OCC_W'(CAPACITY);
    localparam logic [IDX_W-1:0] CAP_M1  = IDX_W'(CAPACITY - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP_OUT,
        S_DUMP_RD,
        S_DUMP_OUT
    } state_t;

    state_t                            state_reg, state_next;
    logic [2:0]                        action_reg, action_next;
    logic signed [drb_pkg::DATA_W-1:0] value_reg, value_next;
    logic [IDX_W-1:0]                  front_reg, front_next;
    logic [OCC_W-1:0]                  occ_reg, occ_next;
    logic [OCC_W-1:0]                  cnt_reg, cnt_next;
    logic                              strobe_reg, strobe_next;
    drb_pkg::result_t                  result_reg, result_next;

    logic [OCC_W-1:0]                  occ_m1;
    logic [IDX_W-1:0]                  offset;
    logic [IDX_W-1:0]                  slot;
    logic                              mem_we;
    logic signed [drb_pkg::DATA_W-1:0] rdata;

    drb_addr_unit #(.CAPACITY(CAPACITY)) u_addr (
        .base   (front_reg),
        .offset (offset),
        .slot   (slot)
    );

    drb_mem #(.CAPACITY(CAPACITY)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .addr  (slot),
        .wdata (value_reg),
        .rdata (rdata)
    );

    assign occ_m1 = occ_reg - OCC_W'(1);

    always_comb
    begin
        if (state_reg == S_POP_OUT)
        begin
            offset = IDX_W'(1);
        end
        else
        begin
            case (action_reg) inside
                drb_pkg::ACT_PUSH_FRONT: offset = CAP_M1;
                drb_pkg::ACT_PUSH_BACK:  offset = IDX_W'(occ_reg);
                drb_pkg::ACT_POP_BACK:   offset = IDX_W'(occ_m1);
                drb_pkg::ACT_DUMP_FWD:   offset = IDX_W'(cnt_reg);
                drb_pkg::ACT_DUMP_BWD:   offset = IDX_W'(occ_m1 - cnt_reg);
                default:                 offset = '0;
            endcase
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        action_next = action_reg;
        value_next  = value_reg;
        front_next  = front_reg;
        occ_next    = occ_reg;
        cnt_next    = cnt_reg;
        strobe_next = 1'b0;
        result_next = result_reg;
        mem_we      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    action_next = request.action;
                    value_next  = request.value;
                    cnt_next    = '0;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                case (action_reg) inside
                    drb_pkg::ACT_PUSH_FRONT, drb_pkg::ACT_PUSH_BACK:
                    begin
                        strobe_next           = 1'b1;
                        result_next.value_res = '0;
                        result_next.last      = 1'b1;
                        if (occ_reg == CAP_OCC)
                        begin
                            result_next.status = drb_pkg::ST_FULL;
                        end
                        else
                        begin
                            result_next.status = drb_pkg::ST_OK;
                            mem_we             = 1'b1;
                            occ_next           = occ_reg + OCC_W'(1);
                            if (action_reg == drb_pkg::ACT_PUSH_FRONT)
                            begin
                                front_next = slot;
                            end
                        end
                    end
                    drb_pkg::ACT_POP_FRONT, drb_pkg::ACT_POP_BACK,
                    drb_pkg::ACT_DUMP_FWD, drb_pkg::ACT_DUMP_BWD:
                    begin
                        if (occ_reg == '0)
                        begin
                            strobe_next           = 1'b1;
                            result_next.status    = drb_pkg::ST_EMPTY;
                            result_next.value_res = '0;
                            result_next.last      = 1'b1;
                        end
                        else if (action_reg == drb_pkg::ACT_POP_FRONT ||
                                 action_reg == drb_pkg::ACT_POP_BACK)
                        begin
                            state_next = S_POP_OUT;
                        end
                        else
                        begin
                            state_next = S_DUMP_OUT;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_POP_OUT:
            begin
                strobe_next           = 1'b1;
                result_next.status    = drb_pkg::ST_OK;
                result_next.value_res = rdata;
                result_next.last      = 1'b1;
                occ_next              = occ_m1;
                if (action_reg == drb_pkg::ACT_POP_FRONT)
                begin
                    front_next = slot;
                end
                state_next = S_IDLE;
            end
            S_DUMP_RD:
            begin
                state_next = S_DUMP_OUT;
            end
            S_DUMP_OUT:
            begin
                strobe_next           = 1'b1;
                result_next.status    = drb_pkg::ST_OK;
                result_next.value_res = rdata;
                result_next.last      = (cnt_reg == occ_m1);
                if (cnt_reg == occ_m1)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next   = cnt_reg + OCC_W'(1);
                    state_next = S_DUMP_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            action_reg <= '0;
            value_reg  <= '0;
            front_reg  <= '0;
            occ_reg    <= '0;
            cnt_reg    <= '0;
            strobe_reg <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            action_reg <= action_next;
            value_reg  <= value_next;
            front_reg  <= front_next;
            occ_reg    <= occ_next;
            cnt_reg    <= cnt_next;
            strobe_reg <= strobe_next;
            result_reg <= result_next;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

>>> hw/rtl/drb_checker.sv
// Port-level checks for the double-ended queue, bound to the top level.
// Depends on drb_pkg and deque_ring_buffer_assert.svh.
`include "deque_ring_buffer_assert.svh"

module drb_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             strobe,
    input drb_pkg::result_t result
);

    `DRB_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `DRB_ASSERT_SAME(a_status_code, clk, rst_n, strobe, result.status != 2'd3)
    `DRB_ASSERT_SAME(a_fail_zero, clk, rst_n, strobe && result.status != drb_pkg::ST_OK, result.value_res == '0 && result.last)
    `DRB_ASSERT_SAME(a_last_idle, clk, rst_n, strobe && result.last, !busy)
    `DRB_ASSERT_NEXT(a_more_busy, clk, rst_n, strobe && !result.last, busy)

endmodule

bind deque_ring_buffer drb_checker u_drb_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
);
